@@ rtl/core/pin_safety_interlock_unit_assert.svh @@
// Assertion macros for the pin safety interlock checker.
`ifndef PIN_SAFETY_INTERLOCK_UNIT_ASSERT_SVH
`define PIN_SAFETY_INTERLOCK_UNIT_ASSERT_SVH

// Clocked assertion, off while reset is asserted.
`define PSI_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define PSI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/core/psi_pkg.sv @@
`timescale 1ns / 1ps

package psi_pkg;

  localparam int PIN_COUNT    = 16;
  localparam int AGE_BITS     = 16;
  localparam int SLOTS        = 16;
  localparam int PIN_IDX_BITS = 4;
  localparam int MASK_BITS    = 16;
  localparam int TIMEOUT_BITS = 16;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_BITS     = 16;
  localparam int CMP_BITS     = (AGE_BITS > TIMEOUT_BITS) ? AGE_BITS : TIMEOUT_BITS;

  // Pins at or above PIN_COUNT are dropped from every mask.
  localparam logic [SLOTS-1:0] VALID_MASK = (PIN_COUNT >= SLOTS) ? {SLOTS{1'b1}} :
      SLOTS'((65'(1) << PIN_COUNT) - 65'(1));

  localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = TIMEOUT_BITS'(10);

  localparam logic [CFG_IDX_BITS-1:0] CFG_REQ_HIGH     = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_REQ_LOW      = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ANY_HIGH     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TIMEOUT      = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LOGIC_MODE   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DEFAULT_SAFE = 3'd5;

  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  localparam logic [1:0] MODE_AND    = 2'd0;
  localparam logic [1:0] MODE_OR     = 2'd1;
  localparam logic [1:0] MODE_CUSTOM = 2'd2;

  // Flags rippled down the row of pin cells.
  typedef struct packed {
    logic timed_out;
    logic req_fail;
    logic any_hit;
  } chain_t;

  // Per-cell mask bits.
  typedef struct packed {
    logic hi;
    logic lo;
    logic any;
  } pin_mask_t;

endpackage

@@ rtl/core/psi_pin_cell.sv @@
`timescale 1ns / 1ps

module psi_pin_cell (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  upd_en_i,
  input  logic                                  tick_en_i,
  input  logic                                  level_i,
  input  logic [psi_pkg::TIMEOUT_BITS-1:0]      timeout_i,
  input  psi_pkg::pin_mask_t                    mask_i,
  input  psi_pkg::chain_t                       chain_i,
  output psi_pkg::chain_t                       chain_o,
  output logic                                  seen_o
);

  logic                         level_q, level_d;
  logic                         seen_q, seen_d;
  logic [psi_pkg::AGE_BITS-1:0] age_q, age_d;
  logic                         too_old;

  always_comb begin
    level_d = level_q;
    seen_d  = seen_q;
    age_d   = age_q;
    if (upd_en_i) begin
      level_d = level_i;
      seen_d  = 1'b1;
      age_d   = '0;
    end else if (tick_en_i && seen_q && (age_q != {psi_pkg::AGE_BITS{1'b1}})) begin
      age_d = age_q + psi_pkg::AGE_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= 1'b0;
      seen_q  <= 1'b0;
      age_q   <= '0;
    end else begin
      level_q <= level_d;
      seen_q  <= seen_d;
      age_q   <= age_d;
    end
  end

  assign too_old = seen_q &&
      (psi_pkg::CMP_BITS'(age_q) > psi_pkg::CMP_BITS'(timeout_i));

  assign chain_o.timed_out = chain_i.timed_out | too_old;
  assign chain_o.req_fail  = chain_i.req_fail |
                             (mask_i.hi & ~level_q) | (mask_i.lo & level_q);
  assign chain_o.any_hit   = chain_i.any_hit | (mask_i.any & level_q);
  assign seen_o            = seen_q;

endmodule

@@ rtl/core/pin_safety_interlock_unit.sv @@
`timescale 1ns / 1ps

// Pin safety interlock.
// Input channel (in_valid_i / in_ready_o) carries one beat per pin update
// (req_type_i = 0, pin_index_i, pin_level_i) or time tick (req_type_i = 1).
// Output channel (out_valid_o / out_ready_i) returns exactly one beat per
// input beat: safe_state_o and state_changed_o, in input order. Config is
// a plain write port (cfg_we_i, cfg_index_i, cfg_wdata_i), to be written
// while the block is idle (not enforced by the block); writes take effect
// at the next beat. A result is held in the cell stage, then in the output
// register. Throughput: one beat per cycle while the output is not stalled.
// An input beat updates the row of 16 pin cells at once; the verdict is
// read from the cell chain when the output register is free. If the
// receiver stalls, one result waits in the output register and one more
// beat is held in the cell stage; in_ready_o then drops until the output
// moves. Reset clears all pin levels, seen marks, ages, the safe flag and
// the config registers (timeout back to 10); no result is pending.
module pin_safety_interlock_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [psi_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [psi_pkg::CFG_BITS-1:0]       cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               req_type_i,
  input  logic [psi_pkg::PIN_IDX_BITS-1:0]   pin_index_i,
  input  logic                               pin_level_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               safe_state_o,
  output logic                               state_changed_o
);

  logic [psi_pkg::MASK_BITS-1:0]    req_high_q, req_low_q, any_high_q;
  logic [psi_pkg::TIMEOUT_BITS-1:0] timeout_q;
  logic [1:0]                       mode_q;
  logic                             default_safe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_high_q     <= '0;
      req_low_q      <= '0;
      any_high_q     <= '0;
      timeout_q      <= psi_pkg::TIMEOUT_RESET;
      mode_q         <= psi_pkg::MODE_AND;
      default_safe_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        psi_pkg::CFG_REQ_HIGH:     req_high_q     <= cfg_wdata_i[psi_pkg::MASK_BITS-1:0];
        psi_pkg::CFG_REQ_LOW:      req_low_q      <= cfg_wdata_i[psi_pkg::MASK_BITS-1:0];
        psi_pkg::CFG_ANY_HIGH:     any_high_q     <= cfg_wdata_i[psi_pkg::MASK_BITS-1:0];
        psi_pkg::CFG_TIMEOUT:      timeout_q      <= cfg_wdata_i[psi_pkg::TIMEOUT_BITS-1:0];
        psi_pkg::CFG_LOGIC_MODE:   mode_q         <= cfg_wdata_i[1:0];
        psi_pkg::CFG_DEFAULT_SAFE: default_safe_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  logic [psi_pkg::SLOTS-1:0] hi_m, lo_m, any_m, monitored;
  assign hi_m      = psi_pkg::SLOTS'(req_high_q) & psi_pkg::VALID_MASK;
  assign lo_m      = psi_pkg::SLOTS'(req_low_q) & psi_pkg::VALID_MASK;
  assign any_m     = psi_pkg::SLOTS'(any_high_q) & psi_pkg::VALID_MASK;
  assign monitored = hi_m | lo_m | any_m;

  logic                      in_beat, is_tick, pin_mon, out_adv;
  logic [psi_pkg::SLOTS-1:0] pin_bit, seen_vec;
  // Cell stage: the beat whose verdict is read from the chain this cycle.
  logic                      s1_valid_q, s1_hold_q, all_seen_q, safe_flag_q;

  assign pin_bit    = psi_pkg::SLOTS'(1) << pin_index_i;
  assign pin_mon    = |(monitored & pin_bit);
  assign is_tick    = (req_type_i == psi_pkg::REQ_TICK);
  assign out_adv    = !out_valid_o || out_ready_i;
  assign in_ready_o = !s1_valid_q || out_adv;
  assign in_beat    = in_valid_i && in_ready_o;

  psi_pkg::chain_t chain [psi_pkg::SLOTS+1];
  assign chain[0] = '0;

  for (genvar g = 0; g < psi_pkg::SLOTS; g++) begin : g_cell
    logic               upd_en;
    psi_pkg::pin_mask_t mask;
    assign upd_en = in_beat && !is_tick && pin_mon &&
                    (pin_index_i == psi_pkg::PIN_IDX_BITS'(g));
    assign mask.hi  = hi_m[g];
    assign mask.lo  = lo_m[g];
    assign mask.any = any_m[g];

    psi_pin_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .upd_en_i  (upd_en),
      .tick_en_i (in_beat && is_tick),
      .level_i   (pin_level_i),
      .timeout_i (timeout_q),
      .mask_i    (mask),
      .chain_i   (chain[g]),
      .chain_o   (chain[g+1]),
      .seen_o    (seen_vec[g])
    );
  end

  logic judge, mode_ok, verdict, changed;

  always_comb begin
    case (mode_q)
      psi_pkg::MODE_AND:    mode_ok = !chain[psi_pkg::SLOTS].req_fail;
      psi_pkg::MODE_OR:     mode_ok = chain[psi_pkg::SLOTS].any_hit;
      psi_pkg::MODE_CUSTOM: mode_ok = !chain[psi_pkg::SLOTS].req_fail &&
                                      ((any_m == '0) || chain[psi_pkg::SLOTS].any_hit);
      default:              mode_ok = 1'b0;
    endcase
    if (!all_seen_q)                              judge = default_safe_q;
    else if (chain[psi_pkg::SLOTS].timed_out)     judge = 1'b0;
    else                                          judge = mode_ok;
    // Unmonitored update repeats the last verdict.
    verdict = s1_hold_q ? safe_flag_q : judge;
    changed = s1_hold_q ? 1'b0 : (judge != safe_flag_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_hold_q   <= 1'b0;
      all_seen_q  <= 1'b0;
      safe_flag_q <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (in_beat) begin
        s1_valid_q <= 1'b1;
        s1_hold_q  <= !is_tick && !pin_mon;
        if (!is_tick && pin_mon && (((seen_vec | pin_bit) & monitored) == monitored)) begin
          all_seen_q <= 1'b1;
        end
      end else if (out_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_valid_q && out_adv) begin
        out_valid_o <= 1'b1;
        safe_flag_q <= verdict;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && out_adv) begin
      safe_state_o    <= verdict;
      state_changed_o <= changed;
    end
  end

endmodule

@@ rtl/core/psi_checker.sv @@
`timescale 1ns / 1ps
`include "pin_safety_interlock_unit_assert.svh"

module psi_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic                              safe_state_o,
  input logic                              state_changed_o
);

  logic last_safe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_safe_q <= 1'b0;
    end else if (out_valid_o && out_ready_i) begin
      last_safe_q <= safe_state_o;
    end
  end

  `PSI_ASSERT_ALWAYS(a_no_result_in_reset, clk_i, !rst_ni |-> !out_valid_o, "result during reset")

  `PSI_ASSERT(a_changed_mark, clk_i, rst_ni, (out_valid_o && out_ready_i) |-> (state_changed_o == (safe_state_o != last_safe_q)), "changed mark disagrees with delivered safe state")

  `PSI_ASSERT(a_ready_only_on_stall, clk_i, rst_ni, !in_ready_o |-> (out_valid_o && !out_ready_i), "input blocked without an output stall")

  `PSI_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(safe_state_o) && $stable(state_changed_o)), "stalled result beat changed")

endmodule

bind pin_safety_interlock_unit psi_checker u_psi_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .safe_state_o    (safe_state_o),
  .state_changed_o (state_changed_o)
);
